FILE: rtl/smtp_ds_pkg.sv
// ----------------------------------------------------------------------------
// smtp_ds_pkg
// Shared types and constants for the SMTP body dot-stuffer: character codes,
// the step masks of one job and the job and result words.
// ----------------------------------------------------------------------------
package smtp_ds_pkg;

    // character codes
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // one bit per output step, sent lowest bit first
    localparam int unsigned STEP_W = 8;
    localparam logic [STEP_W-1:0] STEP_DOT  = 8'h01;  // stuffed dot
    localparam logic [STEP_W-1:0] STEP_DATA = 8'h02;  // the body byte itself
    localparam logic [STEP_W-1:0] STEP_CR   = 8'h04;  // line end
    localparam logic [STEP_W-1:0] STEP_LF   = 8'h08;
    localparam logic [STEP_W-1:0] STEP_TDOT = 8'h10;  // end-of-data terminator
    localparam logic [STEP_W-1:0] STEP_TCR  = 8'h20;
    localparam logic [STEP_W-1:0] STEP_TLF  = 8'h40;
    localparam logic [STEP_W-1:0] STEP_ERR  = 8'h80;  // rejection word

    // one classified input word, as queued between front and back
    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic [7:0]        data;
        logic              done;   // last step closes the message
    } job_t;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       message_done;
        logic       error;
    } result_t;

endpackage

FILE: rtl/smtp_body_dot_stuffer.sv
// ----------------------------------------------------------------------------
// smtp_body_dot_stuffer
// SMTP DATA-phase body encoder: CR LF line endings, dot stuffing, terminator.
// ----------------------------------------------------------------------------
// An input word is taken in any cycle in which the job queue (JOB_DEPTH
// entries) has room, so words arrive back to back. The output sequencer puts
// out one result word per cycle while the output register is free or popped;
// a word causes one result for a plain byte, two for a stuffed dot or a line
// end and up to five for the end marker; a word with no result is not queued.
// Results sit in an output register and are read with pop while empty is low.
// The first bare CR gives one error word and later bytes are dropped until
// the end marker. append_terminator is written through cfg_we and cfg_wdata;
// the user must do so only while the block is idle; the block does not check.
module smtp_body_dot_stuffer
#(
    parameter int unsigned JOB_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  body_byte,
    input  logic        end_marker,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        message_done,
    output logic        error
);

    smtp_ds_pkg::job_t    fe_job;
    smtp_ds_pkg::job_t    be_job;
    smtp_ds_pkg::result_t result;
    logic                 fe_push;
    logic                 q_empty;
    logic                 be_pop;
    logic                 accept;

    assign accept = push && !full;

    // classifier
    smtp_ds_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .body_byte  (body_byte),
        .end_marker (end_marker),
        .job_push   (fe_push),
        .job        (fe_job)
    );

    // job queue
    smtp_ds_fifo #(.DEPTH(JOB_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fe_push),
        .wr_job (fe_job),
        .rd_en  (be_pop),
        .rd_job (be_job),
        .full   (full),
        .empty  (q_empty)
    );

    // output sequencer
    smtp_ds_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (q_empty),
        .job       (be_job),
        .job_pop   (be_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign out_byte     = result.out_byte;
    assign last_of_run  = result.last_of_run;
    assign message_done = result.message_done;
    assign error        = result.error;

endmodule

FILE: rtl/smtp_ds_front.sv
// ----------------------------------------------------------------------------
// smtp_ds_front
// Accepts body words, tracks line and CR state and turns each word into a
// job: the set of output steps it causes.
// ----------------------------------------------------------------------------
module smtp_ds_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                accept,
    input  logic [7:0]          body_byte,
    input  logic                end_marker,
    output logic                job_push,
    output smtp_ds_pkg::job_t   job
);

    logic append_terminator_reg;
    logic line_start_reg, line_start_next;
    logic cr_pending_reg, cr_pending_next;
    logic failed_reg, failed_next;

    // classification of the current word
    always_comb
    begin
        line_start_next = line_start_reg;
        cr_pending_next = cr_pending_reg;
        failed_next     = failed_reg;
        job.steps       = '0;
        job.data        = body_byte;
        job.done        = 1'b0;
        if (end_marker)
        begin
            line_start_next = 1'b1;
            cr_pending_next = 1'b0;
            failed_next     = 1'b0;
            if (!failed_reg)
            begin
                if (cr_pending_reg)
                begin
                    job.steps = smtp_ds_pkg::STEP_ERR;
                end
                else
                begin
                    job.done = 1'b1;
                    if (!line_start_reg)
                    begin
                        job.steps = job.steps | smtp_ds_pkg::STEP_CR | smtp_ds_pkg::STEP_LF;
                    end
                    if (append_terminator_reg)
                    begin
                        job.steps = job.steps | smtp_ds_pkg::STEP_TDOT
                                  | smtp_ds_pkg::STEP_TCR | smtp_ds_pkg::STEP_TLF;
                    end
                end
            end
        end
        else if (!failed_reg)
        begin
            if (cr_pending_reg)
            begin
                cr_pending_next = 1'b0;
                if (body_byte == smtp_ds_pkg::CH_LF)
                begin
                    job.steps       = smtp_ds_pkg::STEP_CR | smtp_ds_pkg::STEP_LF;
                    line_start_next = 1'b1;
                end
                else
                begin
                    job.steps   = smtp_ds_pkg::STEP_ERR;
                    failed_next = 1'b1;
                end
            end
            else if (body_byte == smtp_ds_pkg::CH_CR)
            begin
                cr_pending_next = 1'b1;
            end
            else if (body_byte == smtp_ds_pkg::CH_LF)
            begin
                job.steps       = smtp_ds_pkg::STEP_CR | smtp_ds_pkg::STEP_LF;
                line_start_next = 1'b1;
            end
            else
            begin
                job.steps = smtp_ds_pkg::STEP_DATA;
                if (line_start_reg && (body_byte == smtp_ds_pkg::CH_DOT))
                begin
                    job.steps = job.steps | smtp_ds_pkg::STEP_DOT;
                end
                line_start_next = 1'b0;
            end
        end
    end

    assign job_push = accept && (job.steps != '0);

    // line state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            append_terminator_reg <= 1'b1;
            line_start_reg        <= 1'b1;
            cr_pending_reg        <= 1'b0;
            failed_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                append_terminator_reg <= cfg_wdata;
            end
            if (accept)
            begin
                line_start_reg <= line_start_next;
                cr_pending_reg <= cr_pending_next;
                failed_reg     <= failed_next;
            end
        end
    end

endmodule

FILE: rtl/smtp_ds_fifo.sv
// ----------------------------------------------------------------------------
// smtp_ds_fifo
// Short job queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module smtp_ds_fifo
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  smtp_ds_pkg::job_t   wr_job,
    input  logic                rd_en,
    output smtp_ds_pkg::job_t   rd_job,
    output logic                full,
    output logic                empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    smtp_ds_pkg::job_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full   = (count_reg == FULL_CNT);
    assign empty  = (count_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

FILE: rtl/smtp_ds_back.sv
// ----------------------------------------------------------------------------
// smtp_ds_back
// Output sequencer: walks the steps of one job into the output register, one
// output word per cycle while that register is free or being popped.
// ----------------------------------------------------------------------------
module smtp_ds_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_empty,
    input  smtp_ds_pkg::job_t       job,
    output logic                    job_pop,
    input  logic                    pop,
    output logic                    empty,
    output smtp_ds_pkg::result_t    result
);

    logic [smtp_ds_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [smtp_ds_pkg::STEP_W-1:0] pick;
    logic [smtp_ds_pkg::STEP_W-1:0] rest;
    logic [7:0]                     data_reg;
    logic                           done_reg;
    logic                           out_valid_reg, out_valid_next;
    smtp_ds_pkg::result_t           result_reg, word;
    logic                           emit;
    logic                           last;

    // lowest pending step
    assign pick = steps_reg & (~steps_reg + 1'b1);
    assign rest = steps_reg & ~pick;
    assign last = (rest == '0);
    assign emit = (steps_reg != '0) && (!out_valid_reg || pop);

    // word for the picked step
    always_comb
    begin
        word.last_of_run  = last;
        word.error        = 1'b0;
        word.message_done = last && done_reg;
        case (pick)
            smtp_ds_pkg::STEP_DOT:  word.out_byte = smtp_ds_pkg::CH_DOT;
            smtp_ds_pkg::STEP_DATA: word.out_byte = data_reg;
            smtp_ds_pkg::STEP_CR:   word.out_byte = smtp_ds_pkg::CH_CR;
            smtp_ds_pkg::STEP_LF:   word.out_byte = smtp_ds_pkg::CH_LF;
            smtp_ds_pkg::STEP_TDOT: word.out_byte = smtp_ds_pkg::CH_DOT;
            smtp_ds_pkg::STEP_TCR:  word.out_byte = smtp_ds_pkg::CH_CR;
            smtp_ds_pkg::STEP_TLF:  word.out_byte = smtp_ds_pkg::CH_LF;
            smtp_ds_pkg::STEP_ERR:
            begin
                word.out_byte     = 8'h00;
                word.error        = 1'b1;
                word.message_done = 1'b0;
            end
            default:                word.out_byte = 8'h00;
        endcase
    end

    // job load when the current one is spent
    assign job_pop = !job_empty && ((steps_reg == '0) || (emit && last));

    always_comb
    begin
        steps_next = steps_reg;
        if (emit)
        begin
            steps_next = rest;
        end
        if (job_pop)
        begin
            steps_next = job.steps;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            data_reg <= job.data;
            done_reg <= job.done;
        end
        if (emit)
        begin
            result_reg <= word;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

endmodule

FILE: rtl/smtp_ds_checker.sv
// ----------------------------------------------------------------------------
// smtp_ds_checker
// Port-level checks on the result side of the dot-stuffer.
// ----------------------------------------------------------------------------
module smtp_ds_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_byte,
    input  logic        last_of_run,
    input  logic        message_done,
    input  logic        error
);

    // nothing to read once reset has been seen
    assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    // error word is zero and closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error) |-> (out_byte == 8'h00 && last_of_run && !message_done))
        else $error("malformed error word");

    // message ends on the LF of a line end and closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && message_done) |->
            (last_of_run && !error && out_byte == smtp_ds_pkg::CH_LF))
        else $error("message end not on a closing LF");

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(error)
                              && $stable(last_of_run) && $stable(message_done)))
        else $error("stalled word changed");

endmodule

bind smtp_body_dot_stuffer smtp_ds_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .message_done (message_done),
    .error        (error)
);
